@@ rtl/whlhr_pkg.sv @@
// ---------------------------------------------------------------------------
// whlhr_pkg
// Shared types and constants for the wide line hit region block.
// ---------------------------------------------------------------------------
package whlhr_pkg;

    localparam int COORD_W    = 16;
    localparam int CORNER_W   = 17;
    localparam int RANGE_W    = 8;
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 16;
    localparam int UNIT_LAT   = DIV_STEPS + SQRT_STEPS;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 8'd4;

    typedef enum logic [1:0] {
        KIND_HORZ = 2'd0,
        KIND_VERT = 2'd1,
        KIND_QUAD = 2'd2
    } t_kind;

    // per-request side data carried alongside the root units
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [RANGE_W-1:0]        l;
        t_kind                     kind;
        logic                      neg_by;
    } t_side;

endpackage

@@ rtl/whlhr_if.sv @@
// ---------------------------------------------------------------------------
// whlhr_if
// Valid/ready channels for segment requests and region results.
// ---------------------------------------------------------------------------
interface whlhr_seg_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;

    modport source (output valid, first_x, first_y, second_x, second_y, input ready);
    modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

interface whlhr_region_if;
    logic               valid;
    logic               ready;
    logic [1:0]         region_kind;
    logic signed [16:0] corner0_x;
    logic signed [16:0] corner0_y;
    logic signed [16:0] corner1_x;
    logic signed [16:0] corner1_y;
    logic signed [16:0] corner2_x;
    logic signed [16:0] corner2_y;
    logic signed [16:0] corner3_x;
    logic signed [16:0] corner3_y;

    modport source (output valid, region_kind, corner0_x, corner0_y, corner1_x, corner1_y,
                    corner2_x, corner2_y, corner3_x, corner3_y, input ready);
    modport sink   (input valid, region_kind, corner0_x, corner0_y, corner1_x, corner1_y,
                    corner2_x, corner2_y, corner3_x, corner3_y, output ready);
endinterface

@@ rtl/whlhr_root_unit.sv @@
// ---------------------------------------------------------------------------
// whlhr_root_unit
// Pipelined floor(sqrt(floor(sq * 2^32 / len2))): one quotient bit per
// stage, then one root bit per stage. No valid; the caller tracks it.
// ---------------------------------------------------------------------------
module whlhr_root_unit (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_sq,
    input  logic [33:0] i_len2,
    output logic [15:0] o_root
);

    localparam int DN = whlhr_pkg::DIV_STEPS;
    localparam int SN = whlhr_pkg::SQRT_STEPS;

    logic [33:0] r_drem [0:DN-1];
    logic [33:0] r_dlen [0:DN-1];
    logic [31:0] r_dq   [0:DN-1];

    logic [31:0] r_sn    [0:SN-1];
    logic [17:0] r_srem  [0:SN-1];
    logic [15:0] r_sroot [0:SN-1];

    genvar k;
    generate
        for (k = 0; k < DN; k++) begin : g_div
            logic [33:0] w_rem;
            logic [33:0] w_len;
            logic [31:0] w_q;
            logic [34:0] w_t;
            logic [34:0] w_diff;
            if (k == 0) begin : g_first
                assign w_rem = {2'b00, i_sq};
                assign w_len = i_len2;
                assign w_q   = '0;
            end else begin : g_next
                assign w_rem = r_drem[k-1];
                assign w_len = r_dlen[k-1];
                assign w_q   = r_dq[k-1];
            end
            assign w_t    = {w_rem, 1'b0};
            assign w_diff = w_t - {1'b0, w_len};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dlen[k] <= w_len;
                    if (!w_diff[34]) begin
                        r_drem[k] <= w_diff[33:0];
                        r_dq[k]   <= {w_q[30:0], 1'b1};
                    end else begin
                        r_drem[k] <= w_t[33:0];
                        r_dq[k]   <= {w_q[30:0], 1'b0};
                    end
                end
            end
        end

        for (k = 0; k < SN; k++) begin : g_sqrt
            logic [31:0] w_n;
            logic [17:0] w_rem;
            logic [15:0] w_root;
            logic [19:0] w_acc;
            logic [19:0] w_trial;
            logic [20:0] w_sub;
            if (k == 0) begin : g_first
                assign w_n    = r_dq[DN-1];
                assign w_rem  = '0;
                assign w_root = '0;
            end else begin : g_next
                assign w_n    = r_sn[k-1];
                assign w_rem  = r_srem[k-1];
                assign w_root = r_sroot[k-1];
            end
            assign w_acc   = {w_rem, w_n[31:30]};
            assign w_trial = {2'b00, w_root, 2'b01};
            assign w_sub   = {1'b0, w_acc} - {1'b0, w_trial};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sn[k] <= {w_n[29:0], 2'b00};
                    if (!w_sub[20]) begin
                        r_srem[k]  <= w_sub[17:0];
                        r_sroot[k] <= {w_root[14:0], 1'b1};
                    end else begin
                        r_srem[k]  <= w_acc[17:0];
                        r_sroot[k] <= {w_root[14:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_sroot[SN-1];

endmodule

@@ rtl/wide_line_hit_region.sv @@
// ---------------------------------------------------------------------------
// wide_line_hit_region
// Region within the proximity range around a line segment.
// ---------------------------------------------------------------------------
// One segment request is taken every cycle unless the output stalls. The
// depth is set by the two root units: one quotient bit per stage (32 stages),
// then one root bit per stage (16 stages). A stall on the output freezes the
// whole pipeline and holds the input off; nothing is dropped.
// Write the range register only while the block is idle.
// ---------------------------------------------------------------------------
module wide_line_hit_region (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    whlhr_seg_if.sink            i_seg,
    whlhr_region_if.source       o_region,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data
);

    localparam int LAT = whlhr_pkg::UNIT_LAT;

    logic       en;
    logic [7:0] r_range;

    // stage 0: captured request
    logic              r_v0;
    whlhr_pkg::t_side  r_s0;
    // stage 1: classification and absolute deltas
    logic              r_v1;
    whlhr_pkg::t_side  r_s1;
    logic [15:0]       r_adx, r_ady;
    // stage 2: squares
    logic              r_v2;
    whlhr_pkg::t_side  r_s2;
    logic [31:0]       r_dx2, r_dy2;
    // stage 3: squared length
    logic              r_v3;
    whlhr_pkg::t_side  r_s3;
    logic [31:0]       r_dx2_3, r_dy2_3;
    logic [33:0]       r_len2;
    // alongside the root units
    logic              r_vd [0:LAT-1];
    whlhr_pkg::t_side  r_sd [0:LAT-1];
    // scale stage
    logic              r_vm;
    whlhr_pkg::t_side  r_sm;
    logic [23:0]       r_px, r_py;
    // output register
    logic              r_vo;
    logic [1:0]        r_kind;
    logic signed [16:0] r_c0x, r_c0y, r_c1x, r_c1y, r_c2x, r_c2y, r_c3x, r_c3y;

    logic [15:0] root_x, root_y;

    assign en          = !r_vo || o_region.ready;
    assign i_seg.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= whlhr_pkg::RANGE_RESET;
        end else if (i_cfg_we) begin
            r_range <= i_cfg_data;
        end
    end

    // ---- stage 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0.x1     <= i_seg.first_x;
            r_s0.y1     <= i_seg.first_y;
            r_s0.x2     <= i_seg.second_x;
            r_s0.y2     <= i_seg.second_y;
            r_s0.l      <= r_range;
            r_s0.kind   <= whlhr_pkg::KIND_HORZ;
            r_s0.neg_by <= 1'b0;
        end
    end

    // ---- stage 1
    logic signed [16:0] n_dx, n_dy;
    logic [16:0]        n_adx, n_ady;
    whlhr_pkg::t_side   n_s1;

    always_comb begin
        n_dx  = {r_s0.x2[15], r_s0.x2} - {r_s0.x1[15], r_s0.x1};
        n_dy  = {r_s0.y2[15], r_s0.y2} - {r_s0.y1[15], r_s0.y1};
        n_adx = n_dx[16] ? 17'(-n_dx) : 17'(n_dx);
        n_ady = n_dy[16] ? 17'(-n_dy) : 17'(n_dy);
        n_s1  = r_s0;
        if (r_s0.y1 == r_s0.y2) begin
            n_s1.kind = whlhr_pkg::KIND_HORZ;
        end else if (r_s0.x1 == r_s0.x2) begin
            n_s1.kind = whlhr_pkg::KIND_VERT;
        end else begin
            n_s1.kind = whlhr_pkg::KIND_QUAD;
        end
        // both deltas nonzero for a quad: same sign means by points negative
        n_s1.neg_by = (n_dx[16] == n_dy[16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1    <= n_s1;
            r_adx   <= n_adx[15:0];
            r_ady   <= n_ady[15:0];
            // ---- stage 2
            r_s2    <= r_s1;
            r_dx2   <= r_adx * r_adx;
            r_dy2   <= r_ady * r_ady;
            // ---- stage 3
            r_s3    <= r_s2;
            r_dx2_3 <= r_dx2;
            r_dy2_3 <= r_dy2;
            r_len2  <= {2'b00, r_dx2} + {2'b00, r_dy2};
        end
    end

    whlhr_root_unit u_root_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_dy2_3),
        .i_len2 (r_len2),
        .o_root (root_x)
    );

    whlhr_root_unit u_root_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_dx2_3),
        .i_len2 (r_len2),
        .o_root (root_y)
    );

    genvar k;
    generate
        for (k = 0; k < LAT; k++) begin : g_dly
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vd[k] <= 1'b0;
                end else if (en) begin
                    r_vd[k] <= (k == 0) ? r_v3 : r_vd[(k == 0) ? 0 : k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sd[k] <= (k == 0) ? r_s3 : r_sd[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    // ---- scale stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_vm <= r_vd[LAT-1];
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sm <= r_sd[LAT-1];
            r_px <= r_sd[LAT-1].l * root_x;
            r_py <= r_sd[LAT-1].l * root_y;
        end
    end

    // ---- corner stage
    logic [24:0]        n_bxr, n_byr;
    logic signed [16:0] n_bx, n_by, n_l, n_x1, n_y1, n_x2, n_y2;
    logic signed [16:0] n_c0x, n_c0y, n_c1x, n_c1y, n_c2x, n_c2y, n_c3x, n_c3y;

    always_comb begin
        n_bxr = {1'b0, r_px} + 25'h8000;
        n_byr = {1'b0, r_py} + 25'h8000;
        n_bx  = {8'b0, n_bxr[24:16]};
        n_by  = r_sm.neg_by ? 17'(-{8'b0, n_byr[24:16]}) : {8'b0, n_byr[24:16]};
        n_l   = {9'b0, r_sm.l};
        n_x1  = {r_sm.x1[15], r_sm.x1};
        n_y1  = {r_sm.y1[15], r_sm.y1};
        n_x2  = {r_sm.x2[15], r_sm.x2};
        n_y2  = {r_sm.y2[15], r_sm.y2};
        n_c0x = '0;
        n_c0y = '0;
        n_c1x = '0;
        n_c1y = '0;
        n_c2x = '0;
        n_c2y = '0;
        n_c3x = '0;
        n_c3y = '0;
        case (r_sm.kind)
            whlhr_pkg::KIND_HORZ: begin
                n_c0x = (n_x1 < n_x2) ? n_x1 : n_x2;
                n_c1x = (n_x1 < n_x2) ? n_x2 : n_x1;
                n_c0y = n_y1 - n_l;
                n_c1y = n_y1 + n_l + 17'sd1;
            end
            whlhr_pkg::KIND_VERT: begin
                n_c0y = (n_y1 < n_y2) ? n_y1 : n_y2;
                n_c1y = (n_y1 < n_y2) ? n_y2 : n_y1;
                n_c0x = n_x1 - n_l;
                n_c1x = n_x1 + n_l + 17'sd1;
            end
            default: begin
                n_c0x = n_x1 + n_bx;
                n_c0y = n_y1 + n_by;
                n_c1x = n_x1 - n_bx;
                n_c1y = n_y1 - n_by;
                n_c2x = n_x2 - n_bx;
                n_c2y = n_y2 - n_by;
                n_c3x = n_x2 + n_bx;
                n_c3y = n_y2 + n_by;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind <= r_sm.kind;
            r_c0x  <= n_c0x;
            r_c0y  <= n_c0y;
            r_c1x  <= n_c1x;
            r_c1y  <= n_c1y;
            r_c2x  <= n_c2x;
            r_c2y  <= n_c2y;
            r_c3x  <= n_c3x;
            r_c3y  <= n_c3y;
        end
    end

    assign o_region.valid       = r_vo;
    assign o_region.region_kind = r_kind;
    assign o_region.corner0_x   = r_c0x;
    assign o_region.corner0_y   = r_c0y;
    assign o_region.corner1_x   = r_c1x;
    assign o_region.corner1_y   = r_c1y;
    assign o_region.corner2_x   = r_c2x;
    assign o_region.corner2_y   = r_c2y;
    assign o_region.corner3_x   = r_c3x;
    assign o_region.corner3_y   = r_c3y;

endmodule
